// ===== rtl/core/npt_pkg.sv =====
package npt_pkg;

	// table geometry
	localparam int CAPACITY = 1024;
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);

	// field widths
	localparam int COORD_W = 17;
	localparam int DIST_W  = 18;

	// distance datapath: operands carry a coordinate or the unsigned limit
	localparam int OPND_W = DIST_W + 1;
	localparam int MAG_W  = DIST_W;
	localparam int SUM_W  = 2 * MAG_W;

	localparam logic [DIST_W-1:0] DIST_RESET = DIST_W'(8192);

	// request opcodes
	localparam logic OP_ADD   = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	typedef struct packed {
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
		logic signed [COORD_W-1:0] z;
	} npt_point_t;

	// travels with each operand pair through the distance unit
	typedef struct packed {
		logic             valid;
		logic             first;  // first axis of a sum
		logic             last;   // last axis of a sum
		logic             init;   // sum is the squared limit, not a point
		logic             done;   // final sum of the query
		logic [IDX_W-1:0] idx;
	} npt_tag_t;

endpackage

// ===== rtl/core/npt_req_if.sv =====
interface npt_req_if import npt_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic                      op;
	logic signed [COORD_W-1:0] point_x;
	logic signed [COORD_W-1:0] point_y;
	logic signed [COORD_W-1:0] point_z;

	modport source (output valid, op, point_x, point_y, point_z, input ready);
	modport sink   (input valid, op, point_x, point_y, point_z, output ready);
endinterface

// ===== rtl/core/npt_rsp_if.sv =====
interface npt_rsp_if import npt_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [IDX_W-1:0] nearest_index;
	logic             found;
	logic             rejected;
	logic [CNT_W-1:0] entry_count;

	modport source (output valid, nearest_index, found, rejected, entry_count, input ready);
	modport sink   (input valid, nearest_index, found, rejected, entry_count, output ready);
endinterface

// ===== rtl/core/npt_dist_unit.sv =====
module npt_dist_unit import npt_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic signed [OPND_W-1:0] opnd_a,
	input  logic signed [OPND_W-1:0] opnd_b,
	input  npt_tag_t                 tag_in,
	output logic        [SUM_W-1:0]  sum,
	output npt_tag_t                 tag_out
);

	logic signed [OPND_W:0]  diff;
	logic        [OPND_W:0]  mag_full;
	logic        [MAG_W-1:0] mag_s1;
	logic        [SUM_W-1:0] sq_full;
	logic        [SUM_W-1:0] sq_s2;
	logic        [SUM_W-1:0] acc_s3;
	npt_tag_t                tag_s1;
	npt_tag_t                tag_s2;
	npt_tag_t                tag_s3;

	// stage 1: absolute difference of one axis
	assign diff     = (OPND_W + 1)'(opnd_a) - (OPND_W + 1)'(opnd_b);
	assign mag_full = diff[OPND_W] ? (OPND_W + 1)'(-diff) : (OPND_W + 1)'(diff);

	// stage 2: the one squarer
	assign sq_full = SUM_W'(mag_s1) * SUM_W'(mag_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
			tag_s2 <= '0;
			tag_s3 <= '0;
		end else begin
			tag_s1 <= tag_in;
			tag_s2 <= tag_s1;
			tag_s3 <= tag_s2;
		end
	end

	// datapath, no reset
	always_ff @(posedge clk) begin
		mag_s1 <= mag_full[MAG_W-1:0];
		sq_s2  <= sq_full;
		// stage 3: accumulate the axes of one sum
		if (tag_s2.valid) begin
			acc_s3 <= tag_s2.first ? sq_s2 : acc_s3 + sq_s2;
		end
	end

	// a sum is complete after its last axis
	always_comb begin
		tag_out       = tag_s3;
		tag_out.valid = tag_s3.valid & tag_s3.last;
	end
	assign sum = acc_s3;

`ifndef SYNTHESIS
	a_first_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		tag_s3.valid && tag_s3.last && tag_s2.valid |-> tag_s2.first)
		else $error("axis sequence lost its start after a completed sum");
	a_init_single: assert property (@(posedge clk) disable iff (!arst_n)
		tag_s3.valid && tag_s3.init |-> tag_s3.first && tag_s3.last)
		else $error("limit square spans more than one step");
	a_done_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		tag_s3.valid && tag_s3.done |-> tag_s3.last)
		else $error("query end flagged before its sum completes");
`endif

endmodule

// ===== rtl/core/nearest_point_table.sv =====
// Channel  Dir  Payload                                          Handshake
// req      in   op, point_x, point_y, point_z                    valid/ready
// rsp      out  nearest_index, found, rejected, entry_count      valid/ready
// cfg      in   cfg_wdata (max_distance)                         cfg_we only
//
// Add: the result goes to the result registers, then to the output register once
// that is free. Query: the single distance unit takes one axis of one point per
// cycle, so each point is fed as x, then y, then z.
// Reset empties the table and sets the limit to 8192; the point memory is not
// cleared; slots not below the fill count may be read but never enter a sum.
// A finished result waits in the output register while the next request is
// taken; a second result waits until the first one is taken.
module nearest_point_table import npt_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [DIST_W-1:0] cfg_wdata,
	npt_req_if.sink           req,
	npt_rsp_if.source         rsp
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_INIT,
		S_AX0,
		S_AX1,
		S_AX2,
		S_WAIT,
		S_RESP
	} state_t;

	state_t              state_q;
	logic [DIST_W-1:0]   md_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [CNT_W-1:0]    pt_q;
	logic [CNT_W-1:0]    pt_next;
	npt_point_t          qry_q;
	npt_point_t          rd_q;
	npt_point_t          mem [CAPACITY];
	logic                wr_en;
	logic                rd_en;
	logic [IDX_W-1:0]    rd_addr;

	logic [SUM_W-1:0]    best_q;
	logic [IDX_W-1:0]    best_idx_q;
	logic                found_q;

	logic [IDX_W-1:0]    res_idx_q;
	logic                res_found_q;
	logic                res_rej_q;
	logic [CNT_W-1:0]    res_cnt_q;

	logic                out_valid_q;
	logic [IDX_W-1:0]    out_idx_q;
	logic                out_found_q;
	logic                out_rej_q;
	logic [CNT_W-1:0]    out_cnt_q;

	logic signed [OPND_W-1:0] feed_a;
	logic signed [OPND_W-1:0] feed_b;
	npt_tag_t                 feed_tag;
	logic        [SUM_W-1:0]  dist_sum;
	npt_tag_t                 dist_tag;
	logic                     hit;
	logic                     req_acc;

	assign req.ready = (state_q == S_IDLE);
	assign req_acc   = req.valid & req.ready;
	assign pt_next   = pt_q + 1'b1;
	assign wr_en     = req_acc && (req.op == OP_ADD) && (cnt_q < CNT_W'(CAPACITY));

	// point memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[cnt_q[IDX_W-1:0]] <= '{x: req.point_x, y: req.point_y, z: req.point_z};
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	// sequencer feed: limit square first, then x, y, z of each point
	always_comb begin
		feed_a   = '0;
		feed_b   = '0;
		feed_tag = '0;
		rd_en    = 1'b0;
		rd_addr  = pt_next[IDX_W-1:0];
		unique case (state_q)
			S_INIT: begin
				feed_a         = $signed({1'b0, md_q});
				feed_tag.valid = 1'b1;
				feed_tag.first = 1'b1;
				feed_tag.last  = 1'b1;
				feed_tag.init  = 1'b1;
				feed_tag.done  = (cnt_q == '0);
				rd_en          = 1'b1;
				rd_addr        = '0;
			end
			S_AX0: begin
				feed_a         = OPND_W'(qry_q.x);
				feed_b         = OPND_W'(rd_q.x);
				feed_tag.valid = 1'b1;
				feed_tag.first = 1'b1;
			end
			S_AX1: begin
				feed_a         = OPND_W'(qry_q.y);
				feed_b         = OPND_W'(rd_q.y);
				feed_tag.valid = 1'b1;
			end
			S_AX2: begin
				feed_a         = OPND_W'(qry_q.z);
				feed_b         = OPND_W'(rd_q.z);
				feed_tag.valid = 1'b1;
				feed_tag.last  = 1'b1;
				feed_tag.done  = (pt_next == cnt_q);
				feed_tag.idx   = pt_q[IDX_W-1:0];
				rd_en          = 1'b1;
			end
			default: begin
			end
		endcase
	end

	npt_dist_unit u_dist (
		.clk     (clk),
		.arst_n  (arst_n),
		.opnd_a  (feed_a),
		.opnd_b  (feed_b),
		.tag_in  (feed_tag),
		.sum     (dist_sum),
		.tag_out (dist_tag)
	);

	// strictly closer than the best so far; ties keep the lower slot
	assign hit = !dist_tag.init && (dist_sum < best_q);

	// query payload, no reset
	always_ff @(posedge clk) begin
		if (req_acc) begin
			qry_q <= '{x: req.point_x, y: req.point_y, z: req.point_z};
		end
	end

	// state, search registers and result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			md_q        <= DIST_RESET;
			cnt_q       <= '0;
			pt_q        <= '0;
			best_q      <= '0;
			best_idx_q  <= '0;
			found_q     <= 1'b0;
			res_idx_q   <= '0;
			res_found_q <= 1'b0;
			res_rej_q   <= 1'b0;
			res_cnt_q   <= '0;
			out_valid_q <= 1'b0;
			out_idx_q   <= '0;
			out_found_q <= 1'b0;
			out_rej_q   <= 1'b0;
			out_cnt_q   <= '0;
		end else begin
			if (cfg_we) begin
				md_q <= cfg_wdata;
			end

			// running best over completed sums
			if (dist_tag.valid) begin
				if (dist_tag.init) begin
					best_q     <= dist_sum;
					best_idx_q <= '0;
					found_q    <= 1'b0;
				end else if (hit) begin
					best_q     <= dist_sum;
					best_idx_q <= dist_tag.idx;
					found_q    <= 1'b1;
				end
			end

			// output register drains; in S_RESP a reload takes its place
			if (rsp.valid && rsp.ready && state_q != S_RESP) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (req_acc) begin
						if (req.op == OP_QUERY) begin
							state_q <= S_INIT;
						end else begin
							res_found_q <= 1'b0;
							if (wr_en) begin
								res_idx_q <= cnt_q[IDX_W-1:0];
								res_rej_q <= 1'b0;
								res_cnt_q <= cnt_q + 1'b1;
								cnt_q     <= cnt_q + 1'b1;
							end else begin
								res_idx_q <= '0;
								res_rej_q <= 1'b1;
								res_cnt_q <= cnt_q;
							end
							state_q <= S_RESP;
						end
					end
				end
				S_INIT: begin
					pt_q    <= '0;
					state_q <= (cnt_q == '0) ? S_WAIT : S_AX0;
				end
				S_AX0: state_q <= S_AX1;
				S_AX1: state_q <= S_AX2;
				S_AX2: begin
					pt_q    <= pt_next;
					state_q <= (pt_next == cnt_q) ? S_WAIT : S_AX0;
				end
				S_WAIT: begin
					if (dist_tag.valid && dist_tag.done) begin
						if (dist_tag.init) begin
							res_idx_q   <= '0;
							res_found_q <= 1'b0;
						end else begin
							res_idx_q   <= hit ? dist_tag.idx : best_idx_q;
							res_found_q <= hit | found_q;
						end
						res_rej_q <= 1'b0;
						res_cnt_q <= cnt_q;
						state_q   <= S_RESP;
					end
				end
				S_RESP: begin
					if (!out_valid_q || rsp.ready) begin
						out_valid_q <= 1'b1;
						out_idx_q   <= res_idx_q;
						out_found_q <= res_found_q;
						out_rej_q   <= res_rej_q;
						out_cnt_q   <= res_cnt_q;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign rsp.valid         = out_valid_q;
	assign rsp.nearest_index = out_idx_q;
	assign rsp.found         = out_found_q;
	assign rsp.rejected      = out_rej_q;
	assign rsp.entry_count   = out_cnt_q;

`ifndef SYNTHESIS
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(CAPACITY))
		else $error("fill count beyond capacity");
	a_scan_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_AX0 || state_q == S_AX1 || state_q == S_AX2) |-> pt_q < cnt_q)
		else $error("scan reads a slot that was never written");
	a_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		dist_tag.valid && dist_tag.done |-> state_q == S_WAIT)
		else $error("query end arrived outside the wait state");
	a_full_holds: assert property (@(posedge clk) disable iff (!arst_n)
		req_acc && cnt_q == CNT_W'(CAPACITY) |=> cnt_q == CNT_W'(CAPACITY))
		else $error("full table changed its count");
`endif

endmodule

// ===== verif/nearest_point_table_tb.sv =====
module nearest_point_table_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import npt_pkg::*;

	localparam int COORD_MIN      = -(1 << (COORD_W - 1));
	localparam int COORD_MAX      = (1 << (COORD_W - 1)) - 1;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam int END_WAIT       = 20;
	localparam int RANDOM_ITEMS   = 580;
	localparam int RANDOM_PHASES  = 7;
	localparam int RANDOM_FILL    = 300;   // keeps scans short in the random part
	localparam int MAX_PRINTED    = 50;
	localparam logic [DIST_W-1:0] LIMIT_MAX = {DIST_W{1'b1}};

	typedef struct packed {
		logic [IDX_W-1:0] nearest_index;
		logic             found;
		logic             rejected;
		logic [CNT_W-1:0] entry_count;
	} npt_result_t;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              cfg_we;
	logic [DIST_W-1:0] cfg_wdata;

	npt_req_if req_ch ();
	npt_rsp_if rsp_ch ();

	nearest_point_table i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req       (req_ch),
		.rsp       (rsp_ch)
	);

	// mirror of the point table and the limit register
	int                pts_x [CAPACITY];
	int                pts_y [CAPACITY];
	int                pts_z [CAPACITY];
	int                point_count = 0;
	logic [DIST_W-1:0] limit_model = DIST_RESET;

	npt_result_t awaited_results [$];
	int          errors       = 0;
	int          stall_cycles = 0;
	bit          quiet        = 1'b0;   // no idling on either side

	always #5 clk = ~clk;

	function automatic longint dist_sq(int ax, int ay, int az, int bx, int by, int bz);
		longint dx, dy, dz;
		dx = longint'(ax) - longint'(bx);
		dy = longint'(ay) - longint'(by);
		dz = longint'(az) - longint'(bz);
		return dx * dx + dy * dy + dz * dz;
	endfunction

	// append or search, updating the mirrored table; returns the result due
	function automatic npt_result_t apply_request(logic op, int px, int py, int pz);
		npt_result_t r;
		longint      best, d2;
		r = '0;
		if (op == OP_ADD) begin
			if (point_count < CAPACITY) begin
				pts_x[point_count] = px;
				pts_y[point_count] = py;
				pts_z[point_count] = pz;
				r.nearest_index = IDX_W'(point_count);
				point_count++;
			end else begin
				r.rejected = 1'b1;
			end
		end else begin
			best = longint'(limit_model) * longint'(limit_model);
			for (int i = 0; i < point_count; i++) begin
				d2 = dist_sq(px, py, pz, pts_x[i], pts_y[i], pts_z[i]);
				// strict compare: ties stay with the lower slot
				if (d2 < best) begin
					best = d2;
					r.nearest_index = IDX_W'(i);
					r.found = 1'b1;
				end
			end
		end
		r.entry_count = CNT_W'(point_count);
		return r;
	endfunction

	function automatic int clamp_coord(int v);
		if (v < COORD_MIN)
			return COORD_MIN;
		if (v > COORD_MAX)
			return COORD_MAX;
		return v;
	endfunction

	function automatic int any_coord();
		return int'($urandom_range(0, (1 << COORD_W) - 1)) + COORD_MIN;
	endfunction

	function automatic int edge_coord();
		case ($urandom_range(0, 4))
			0: return COORD_MIN;
			1: return COORD_MAX;
			2: return 0;
			3: return -1;
			default: return any_coord();
		endcase
	endfunction

	// mix of corner, full-range and clustered points; clusters make hits likely
	task automatic make_point(output int x, output int y, output int z);
		case ($urandom_range(0, 7))
			0: begin
				x = edge_coord();
				y = edge_coord();
				z = edge_coord();
			end
			1, 2: begin
				x = any_coord();
				y = any_coord();
				z = any_coord();
			end
			default: begin
				x = int'($urandom_range(0, 4000)) - 2000;
				y = int'($urandom_range(0, 4000)) - 2000;
				z = int'($urandom_range(0, 4000)) - 2000;
			end
		endcase
	endtask

	task automatic report_error(input string msg);
		errors++;
		if (errors <= MAX_PRINTED)
			$display("ERROR at %0t: %s", $time, msg);
	endtask

	// one request; valid is held across back-to-back requests
	task automatic send_request(input logic op, input int px, input int py, input int pz);
		int gap;
		if (!quiet && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 14);
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid   <= 1'b1;
		req_ch.op      <= op;
		req_ch.point_x <= COORD_W'(px);
		req_ch.point_y <= COORD_W'(py);
		req_ch.point_z <= COORD_W'(pz);
		do
			@(posedge clk);
		while (!req_ch.ready);
		awaited_results.push_back(apply_request(op, px, py, pz));
	endtask

	task automatic drain_requests();
		req_ch.valid <= 1'b0;
		while (awaited_results.size() != 0)
			@(posedge clk);
	endtask

	// every request yields a result, so an empty queue means the block is idle
	task automatic write_limit(input logic [DIST_W-1:0] value);
		drain_requests();
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we      <= 1'b0;
		limit_model = value;
	endtask

	task automatic test_empty_query();
		send_request(OP_QUERY, 0, 0, 0);
		send_request(OP_QUERY, COORD_MIN, COORD_MAX, 0);
	endtask

	task automatic test_extreme_points();
		write_limit(DIST_RESET);
		send_request(OP_ADD, COORD_MIN, COORD_MIN, COORD_MIN);
		send_request(OP_ADD, COORD_MAX, COORD_MAX, COORD_MAX);
		send_request(OP_ADD, 0, 0, 0);
		send_request(OP_ADD, 0, 0, 0);            // duplicate: tie goes to the lower slot
		send_request(OP_ADD, 5000, -3, 7);
		send_request(OP_ADD, COORD_MIN, COORD_MAX, -1);
		send_request(OP_QUERY, 0, 0, 0);
		send_request(OP_QUERY, 8192, 0, 0);       // exactly at the limit from the origin
		send_request(OP_QUERY, COORD_MAX, COORD_MAX, COORD_MAX);
		send_request(OP_QUERY, 30000, 30000, 30000);
	endtask

	task automatic test_limits();
		// zero limit matches nothing, even an exact hit
		write_limit('0);
		send_request(OP_QUERY, 0, 0, 0);
		// limit of one: only exact hits
		write_limit(DIST_W'(1));
		send_request(OP_QUERY, 0, 0, 0);
		send_request(OP_QUERY, 1, 0, 0);
		write_limit(LIMIT_MAX);
		send_request(OP_QUERY, COORD_MAX, COORD_MAX, COORD_MAX);
		send_request(OP_QUERY, COORD_MIN, COORD_MIN, COORD_MIN);
		send_request(OP_QUERY, COORD_MAX, COORD_MIN, 0);
		write_limit(DIST_W'(131072));
		send_request(OP_QUERY, COORD_MAX, COORD_MIN, 0);
	endtask

	task automatic test_random_traffic();
		int x, y, z, s, spread;
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			case (phase)
				0: write_limit(DIST_RESET);
				1: write_limit(DIST_W'(1));
				2: write_limit(DIST_W'(131072));
				3: write_limit(LIMIT_MAX);
				4: write_limit('0);
				5: write_limit(DIST_W'($urandom_range(1, 4000)));
				default: write_limit(DIST_W'($urandom_range(1, (1 << DIST_W) - 1)));
			endcase
			for (int n = 0; n < RANDOM_ITEMS / RANDOM_PHASES; n++) begin
				if (point_count < RANDOM_FILL && $urandom_range(0, 9) < 4) begin
					// add: sometimes a copy of a stored point to build ties
					if (point_count > 0 && $urandom_range(0, 4) == 0) begin
						s = $urandom_range(0, point_count - 1);
						send_request(OP_ADD, pts_x[s], pts_y[s], pts_z[s]);
					end else begin
						make_point(x, y, z);
						send_request(OP_ADD, x, y, z);
					end
				end else if (point_count > 0 && $urandom_range(0, 9) < 6) begin
					// query near a stored point, offset on the scale of the limit
					s      = $urandom_range(0, point_count - 1);
					spread = int'(limit_model) / 2 + 1;
					if (spread > -COORD_MIN)
						spread = -COORD_MIN;
					x = clamp_coord(pts_x[s] + int'($urandom_range(0, 2 * spread)) - spread);
					y = clamp_coord(pts_y[s] + int'($urandom_range(0, 2 * spread)) - spread);
					z = clamp_coord(pts_z[s] + int'($urandom_range(0, 2 * spread)) - spread);
					send_request(OP_QUERY, x, y, z);
				end else begin
					make_point(x, y, z);
					send_request(OP_QUERY, x, y, z);
				end
			end
		end
	endtask

	task automatic test_full_table();
		int x, y, z;
		while (point_count < CAPACITY - 1) begin
			make_point(x, y, z);
			send_request(OP_ADD, x, y, z);
		end
		send_request(OP_ADD, COORD_MAX, COORD_MIN, 12345);
		// table full: these are refused
		send_request(OP_ADD, COORD_MIN, COORD_MIN, COORD_MIN);
		send_request(OP_ADD, COORD_MAX, COORD_MAX, COORD_MAX);
		send_request(OP_ADD, 0, 0, 0);
		// exact hit on the last slot
		write_limit(DIST_W'(1));
		send_request(OP_QUERY, COORD_MAX, COORD_MIN, 12345);
		write_limit(LIMIT_MAX);
		make_point(x, y, z);
		send_request(OP_QUERY, x, y, z);
		write_limit(DIST_RESET);
		send_request(OP_QUERY, 0, 0, 0);
	endtask

	// result sink: random stall bursts, always ready once quiet
	initial begin
		int n;
		rsp_ch.ready <= 1'b0;
		@(posedge clk);
		forever begin
			if (quiet) begin
				rsp_ch.ready <= 1'b1;
				@(posedge clk);
			end else if ($urandom_range(0, 3) == 0) begin
				n = $urandom_range(1, 14);
				rsp_ch.ready <= 1'b0;
				repeat (n) @(posedge clk);
			end else begin
				n = $urandom_range(1, 30);
				rsp_ch.ready <= 1'b1;
				repeat (n) @(posedge clk);
			end
		end
	end

	// result check and watchdog
	always @(posedge clk) begin
		npt_result_t want;
		if (arst_n) begin
			if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
				stall_cycles = 0;
			else
				stall_cycles++;
			if (stall_cycles >= WATCHDOG_LIMIT) begin
				$display("simulation failed");
				$finish;
			end
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (awaited_results.size() == 0) begin
					report_error("result with no request outstanding");
				end else begin
					want = awaited_results.pop_front();
					if (rsp_ch.nearest_index !== want.nearest_index)
						report_error($sformatf("nearest_index %0d, expected %0d",
							rsp_ch.nearest_index, want.nearest_index));
					if (rsp_ch.found !== want.found)
						report_error($sformatf("found %b, expected %b",
							rsp_ch.found, want.found));
					if (rsp_ch.rejected !== want.rejected)
						report_error($sformatf("rejected %b, expected %b",
							rsp_ch.rejected, want.rejected));
					if (rsp_ch.entry_count !== want.entry_count)
						report_error($sformatf("entry_count %0d, expected %0d",
							rsp_ch.entry_count, want.entry_count));
				end
			end
		end
	end

	initial begin
		arst_n         <= 1'b0;
		cfg_we         <= 1'b0;
		cfg_wdata      <= '0;
		req_ch.valid   <= 1'b0;
		req_ch.op      <= OP_ADD;
		req_ch.point_x <= '0;
		req_ch.point_y <= '0;
		req_ch.point_z <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_query();
		test_extreme_points();
		test_limits();
		test_random_traffic();
		quiet = 1'b1;
		test_full_table();

		drain_requests();
		repeat (END_WAIT) @(posedge clk);
		if (errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

// ===== nearest_point_table.f =====
rtl/core/npt_pkg.sv
rtl/core/npt_req_if.sv
rtl/core/npt_rsp_if.sv
rtl/core/npt_dist_unit.sv
rtl/core/nearest_point_table.sv
verif/nearest_point_table_tb.sv
